### src/kth_smallest_select_unit_defines.svh
// Assertion macros for the selection unit.
// Used by the top level; needs no other file.
`ifndef KTH_SMALLEST_SELECT_UNIT_DEFINES_SVH
`define KTH_SMALLEST_SELECT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define KSS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define KSS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KSS_ASSERT(label, clk, rstn, prop, msg)
`define KSS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### src/kss_pkg.sv
// Shared types and constants of the k-th smallest selection unit.
// Used by every module in src; depends on nothing.
package kss_pkg;
    localparam int MaxSamples = 1024;
    localparam int AddrW = $clog2(MaxSamples);
    localparam int CntW = $clog2(MaxSamples + 1);

    localparam logic [0:0] RegMedianMode = 1'd0;
    localparam logic [0:0] RegRank = 1'd1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_FETCH,
        ST_PASS_START,
        ST_PASS_RUN,
        ST_PASS_LAST,
        ST_DECIDE,
        ST_OUT
    } state_t;

    // Handshake between the sequencer and the counting unit.
    typedef struct packed {
        logic start;
        logic run;
    } cnt_ctrl_t;
endpackage

### src/kth_smallest_select_unit.sv
// Top level of the k-th smallest selection unit: sequencer, registers, store.
// Depends on kss_pkg, kss_sample_ram, kss_count_unit and the defines header.
//
// Samples are taken one per cycle while the set loads. After the closing item
// the unit tries each stored sample in turn as the candidate and counts, in one
// sweep over the store through its single read port, how many samples are
// below and equal to it; the candidate whose range of ranks covers the target
// is the answer. Per candidate the sequencer passes through a fetch state, a
// clear state, a sweep of the whole store, a settle state and a decide state,
// and it stops at the first candidate that fits. The result waits in an output
// register; the next set loads after the result is taken.
`include "kth_smallest_select_unit_defines.svh"
module kth_smallest_select_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sample_value,
    input  logic               s_last_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_selected_value,
    output logic [10:0]        m_set_count,
    output logic               m_rank_out_of_range,
    output logic               m_overflowed,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [9:0]         cfg_data
);
    localparam int AW = kss_pkg::AddrW;
    localparam int CW = kss_pkg::CntW;

    kss_pkg::state_t state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic ovf_reg, ovf_next;
    logic median_reg;
    logic [9:0] rank_reg;
    logic [CW-1:0] target_reg, target_next;
    logic oor_reg, oor_next;
    logic [AW-1:0] cand_idx_reg, cand_idx_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic signed [31:0] cand_reg, cand_next;
    logic signed [31:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] less_cnt, eq_cnt;
    kss_pkg::cnt_ctrl_t cctl;
    logic accept, wr_en, cand_fits, cand_last;
    logic [CW-1:0] kept, rank_ext, med_rank;
    logic [CW:0] hi_rank;

    assign s_ready = (state_reg == kss_pkg::ST_LOAD);
    assign accept = s_valid && s_ready;
    assign wr_en = accept && (fill_reg < CW'(kss_pkg::MaxSamples));
    assign kept = wr_en ? fill_reg + 1'b1 : fill_reg;
    assign rank_ext = CW'(rank_reg);
    assign med_rank = (kept - 1'b1) >> 1;
    assign hi_rank = {1'b0, less_cnt} + {1'b0, eq_cnt};
    assign cand_fits = (less_cnt <= target_reg) && ({1'b0, target_reg} < hi_rank);
    assign cand_last = ({1'b0, cand_idx_reg} == (fill_reg - 1'b1));

    // Read address: the sweep index while counting, otherwise the candidate.
    always_comb begin
        if (state_reg == kss_pkg::ST_PASS_RUN) begin
            rd_addr = scan_reg[AW-1:0];
        end else begin
            rd_addr = cand_idx_reg;
        end
    end

    kss_sample_ram u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(fill_reg[AW-1:0]),
        .wr_data(s_sample_value),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    kss_count_unit u_cnt (
        .aclk    (aclk),
        .ctrl    (cctl),
        .cand    (cand_reg),
        .sample  (rd_data),
        .less_cnt(less_cnt),
        .eq_cnt  (eq_cnt)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kss_pkg::ST_LOAD: begin
                if (accept && s_last_sample) begin
                    state_next = kss_pkg::ST_PASS_FETCH;
                end
            end
            kss_pkg::ST_PASS_FETCH: state_next = kss_pkg::ST_PASS_START;
            kss_pkg::ST_PASS_START: state_next = kss_pkg::ST_PASS_RUN;
            kss_pkg::ST_PASS_RUN: begin
                if (scan_reg == fill_reg) begin
                    state_next = kss_pkg::ST_PASS_LAST;
                end
            end
            kss_pkg::ST_PASS_LAST: state_next = kss_pkg::ST_DECIDE;
            kss_pkg::ST_DECIDE: begin
                if (cand_fits || cand_last) begin
                    state_next = kss_pkg::ST_OUT;
                end else begin
                    state_next = kss_pkg::ST_PASS_FETCH;
                end
            end
            kss_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = kss_pkg::ST_LOAD;
                end
            end
            default: state_next = kss_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        ovf_next = ovf_reg;
        target_next = target_reg;
        oor_next = oor_reg;
        cand_idx_next = cand_idx_reg;
        scan_next = scan_reg;
        cand_next = cand_reg;
        cctl = '0;
        unique case (state_reg)
            kss_pkg::ST_LOAD: begin
                if (accept) begin
                    fill_next = kept;
                    if (!wr_en) begin
                        ovf_next = 1'b1;
                    end
                    if (s_last_sample) begin
                        cand_idx_next = '0;
                        if (median_reg) begin
                            target_next = med_rank;
                            oor_next = 1'b0;
                        end else if (rank_ext >= kept) begin
                            target_next = kept - 1'b1;
                            oor_next = 1'b1;
                        end else begin
                            target_next = rank_ext;
                            oor_next = 1'b0;
                        end
                    end
                end
            end
            // The candidate address is presented here so its data is ready next cycle.
            kss_pkg::ST_PASS_FETCH: ;
            kss_pkg::ST_PASS_START: begin
                // Candidate data arrives now; clear counters, start the sweep.
                cand_next = rd_data;
                cctl.start = 1'b1;
                scan_next = '0;
            end
            kss_pkg::ST_PASS_RUN: begin
                // Read data is registered, so it belongs to the previous sweep address.
                cctl.run = (scan_reg != '0);
                if (scan_reg != fill_reg) begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            kss_pkg::ST_PASS_LAST: ;
            kss_pkg::ST_DECIDE: begin
                if (!(cand_fits || cand_last)) begin
                    cand_idx_next = cand_idx_reg + 1'b1;
                end
            end
            kss_pkg::ST_OUT: begin
                if (m_ready) begin
                    fill_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kss_pkg::ST_LOAD;
            fill_reg <= '0;
            ovf_reg <= 1'b0;
            median_reg <= 1'b1;
            rank_reg <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            ovf_reg <= ovf_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    kss_pkg::RegMedianMode: median_reg <= cfg_data[0];
                    kss_pkg::RegRank: rank_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        target_reg <= target_next;
        oor_reg <= oor_next;
        cand_idx_reg <= cand_idx_next;
        scan_reg <= scan_next;
        cand_reg <= cand_next;
    end

    assign m_valid = (state_reg == kss_pkg::ST_OUT);
    assign m_selected_value = cand_reg;
    assign m_set_count = 11'(fill_reg);
    assign m_rank_out_of_range = oor_reg;
    assign m_overflowed = ovf_reg;

    `KSS_ASSERT(a_ready_excl, aclk, aresetn, !(s_ready && m_valid), "ready during result")
    `KSS_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= CW'(kss_pkg::MaxSamples), "fill over")
    `KSS_ASSERT(a_out_nonempty, aclk, aresetn, m_valid |-> fill_reg != '0, "empty set result")
    `KSS_ASSERT(a_clear_after, aclk, aresetn, (m_valid && m_ready) |=> fill_reg == '0, "no clear")
endmodule

### src/kss_sample_ram.sv
// Sample store: one write port and one registered read port.
// Depends on kss_pkg.
module kss_sample_ram (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [kss_pkg::AddrW-1:0] wr_addr,
    input  logic [31:0]              wr_data,
    input  logic [kss_pkg::AddrW-1:0] rd_addr,
    output logic [31:0]              rd_data
);
    logic [31:0] mem [kss_pkg::MaxSamples];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### src/kss_count_unit.sv
// Shared compare-and-count unit: per pass it counts stored samples below and
// equal to a candidate. Depends on kss_pkg.
module kss_count_unit (
    input  logic                   aclk,
    input  kss_pkg::cnt_ctrl_t     ctrl,
    input  logic signed [31:0]     cand,
    input  logic signed [31:0]     sample,
    output logic [kss_pkg::CntW-1:0] less_cnt,
    output logic [kss_pkg::CntW-1:0] eq_cnt
);
    logic [kss_pkg::CntW-1:0] less_reg, less_next, eq_reg, eq_next;

    always_comb begin
        less_next = less_reg;
        eq_next = eq_reg;
        if (ctrl.start) begin
            less_next = '0;
            eq_next = '0;
        end else if (ctrl.run) begin
            if (sample < cand) begin
                less_next = less_reg + 1'b1;
            end
            if (sample == cand) begin
                eq_next = eq_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        less_reg <= less_next;
        eq_reg <= eq_next;
    end

    assign less_cnt = less_reg;
    assign eq_cnt = eq_reg;
endmodule

### verif/kss_select_checker.sv
// Checker for the k-th smallest selection unit: predicts each closed set's result.
// Watches the sample, result and register write ports; depends on kss_pkg.
module kss_select_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_sample_value,
    input  logic               s_last_sample,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_selected_value,
    input  logic [10:0]        m_set_count,
    input  logic               m_rank_out_of_range,
    input  logic               m_overflowed,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [9:0]         cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 sets_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] value;
        logic [10:0]        count;
        logic               oor;
        logic               ovf;
    } selection_t;

    logic signed [31:0] kept_samples[$];
    selection_t         selections_due[$];
    logic               dropped_flag;
    logic               median_sel;
    logic [9:0]         rank_reg;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Sorts the kept set and picks the entry at the active rank.
    function automatic selection_t select_ranked(input logic mm, input logic [9:0] rk,
                                                 input logic ovf);
        logic signed [31:0] sorted[$];
        logic signed [31:0] v;
        selection_t         r;
        int                 n;
        int                 j;
        int                 k;
        sorted = kept_samples;
        n = sorted.size();
        for (int i = 1; i < n; i++) begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        k = mm ? (n - 1) / 2 : int'(rk);
        r.oor = (k >= n);
        if (r.oor) begin
            k = n - 1;
        end
        r.value = sorted[k];
        r.count = n[10:0];
        r.ovf = ovf;
        return r;
    endfunction

    always @(posedge aclk) begin
        selection_t want;
        logic       was_full;
        if (!aresetn) begin
            kept_samples.delete();
            selections_due.delete();
            dropped_flag <= 1'b0;
            median_sel <= 1'b1;
            rank_reg <= '0;
            fail_count = 0;
            sets_checked <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == kss_pkg::RegMedianMode) begin
                    median_sel <= cfg_data[0];
                end else if (cfg_index == kss_pkg::RegRank) begin
                    rank_reg <= cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                // A sample is dropped when it arrives with the store already full.
                was_full = (kept_samples.size() >= kss_pkg::MaxSamples);
                if (!was_full) begin
                    kept_samples = {kept_samples, s_sample_value};
                end
                if (s_last_sample) begin
                    selections_due = {selections_due, select_ranked(median_sel, rank_reg,
                                                                    dropped_flag || was_full)};
                    kept_samples.delete();
                    dropped_flag <= 1'b0;
                end else if (was_full) begin
                    dropped_flag <= 1'b1;
                end
            end
            if (m_valid && m_ready) begin
                if (selections_due.size() == 0) begin
                    report_mismatch("result without a closed set", 32'd1, 32'd0);
                end else begin
                    want = selections_due.pop_front();
                    sets_checked <= sets_checked + 1;
                    if (m_selected_value !== want.value)
                        report_mismatch("selected_value", m_selected_value, want.value);
                    if (m_set_count !== want.count)
                        report_mismatch("set_count", 32'(m_set_count), 32'(want.count));
                    if (m_rank_out_of_range !== want.oor)
                        report_mismatch("rank_out_of_range", 32'(m_rank_out_of_range),
                                        32'(want.oor));
                    if (m_overflowed !== want.ovf)
                        report_mismatch("overflowed", 32'(m_overflowed), 32'(want.ovf));
                end
            end
        end
        pending = selections_due.size();
    end
endmodule

### verif/kth_smallest_select_unit_tb.sv
// Testbench top for kth_smallest_select_unit: clock, reset, stimulus and verdict.
// Depends on kss_pkg, the unit itself and kss_select_checker.
module kth_smallest_select_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 4000000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_sample_value;
    logic               s_last_sample;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_selected_value;
    logic [10:0]        m_set_count;
    logic               m_rank_out_of_range;
    logic               m_overflowed;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [9:0]         cfg_data;

    int fail_count;
    int pending;
    int sets_checked;
    int cycle_count = 0;
    int samples_sent;
    int send_idle_pct;
    int recv_idle_pct;
    logic recv_hold;

    kth_smallest_select_unit i_dut (.*);

    kss_select_checker i_checker (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    int hold_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else if (recv_hold && hold_left == 0) begin
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            if (hold_left == 1) begin
                hold_left <= 0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_sample(input logic [31:0] value, input logic last);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_value <= value;
        s_last_sample <= last;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        samples_sent++;
    endtask

    // Waits between edges so the checker has already seen the last closing item.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [9:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000 | $urandom_range(3);
            1: return 32'h7FFF_FFFC | $urandom_range(3);
            2: return $urandom_range(7) - 3;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_set();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            send_sample(pick_value(), i == n - 1);
        end
    endtask

    task automatic random_config();
        int r;
        r = $urandom_range(9);
        write_reg(kss_pkg::RegMedianMode, 1'($urandom_range(1)));
        write_reg(kss_pkg::RegRank,
                  r == 0 ? 10'd1023 : r == 1 ? 10'd0 : 10'($urandom_range(15)));
    endtask

    task automatic random_phase(input int sample_goal);
        int goal;
        goal = samples_sent + sample_goal;
        while (samples_sent < goal) begin
            if ($urandom_range(7) == 0) begin
                random_config();
            end
            send_random_set();
        end
    endtask

    initial begin
        s_valid = 1'b0;
        s_sample_value = '0;
        s_last_sample = 1'b0;
        cfg_we = 1'b0;
        cfg_index = kss_pkg::RegMedianMode;
        cfg_data = '0;
        recv_hold = 1'b0;
        samples_sent = 0;
        send_idle_pct = 30;
        recv_idle_pct = 67;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: lower median at reset, odd and even sets, duplicates.
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'hFFFF_0000, 1'b0);
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'hFFFF_0000, 1'b1);
        // Rank register: smallest, in range, and far beyond the set.
        write_reg(kss_pkg::RegMedianMode, 1'b0);
        write_reg(kss_pkg::RegRank, 10'd0);
        send_sample(32'h0000_0005, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        write_reg(kss_pkg::RegRank, 10'd2);
        send_sample(32'h0000_0003, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h0000_0002, 1'b1);
        write_reg(kss_pkg::RegRank, 10'd1023);
        send_sample(32'h0000_0004, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        write_reg(kss_pkg::RegMedianMode, 1'b1);

        random_phase(150);
        // Hold the receiver off while further sets wait at the sender behind the result.
        recv_hold <= 1'b1;
        @(posedge aclk);
        recv_hold <= 1'b0;
        for (int i = 0; i < 4; i++) begin
            send_random_set();
        end
        drain_results();

        send_idle_pct = 67;
        recv_idle_pct = 30;
        random_phase(120);
        // Overfull set of equal samples; the closing sample itself is dropped.
        begin
            logic [31:0] fill;
            fill = $urandom();
            for (int i = 0; i < kss_pkg::MaxSamples + 2; i++) begin
                send_sample(fill, i == kss_pkg::MaxSamples + 1);
            end
        end
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(100);
        drain_results();
        repeat (20) @(posedge aclk);

        $display("Checked %0d closed sets from %0d samples, median and rank modes,",
                 sets_checked, samples_sent);
        $display("including rank overruns, a full store with drops and stalls on both sides.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
